FILE: design/aavr_pkg.sv
package aavr_pkg;

  localparam int COORD_WIDTH = 24;
  localparam int ANGLE_BITS  = 16;

  // Internal fixed-point formats are independent of the coordinate format.
  localparam int MAG_W        = 31;  // scaled axis magnitude, top bit at 2^30
  localparam int QW           = 32;  // signed Q2.30
  localparam int PHASE_W      = 31;  // half-angle phase, 2^32 per turn
  localparam int CORDIC_STEPS = 30;

  localparam logic signed [32:0] CORDIC_GAIN = 33'sd652032875;

  typedef struct packed {
    logic signed [COORD_WIDTH-1:0] vec_x;
    logic signed [COORD_WIDTH-1:0] vec_y;
    logic signed [COORD_WIDTH-1:0] vec_z;
    logic signed [COORD_WIDTH-1:0] axis_x;
    logic signed [COORD_WIDTH-1:0] axis_y;
    logic signed [COORD_WIDTH-1:0] axis_z;
    logic [ANGLE_BITS-1:0]         turn_angle;
  } in_t;

  typedef struct packed {
    logic signed [COORD_WIDTH-1:0] out_x;
    logic signed [COORD_WIDTH-1:0] out_y;
    logic signed [COORD_WIDTH-1:0] out_z;
    logic                          axis_null;
  } out_t;

  // Classified word passed from the front end to the rotation pipeline.
  typedef struct packed {
    logic                           nul;
    logic                           swap;
    logic [PHASE_W-2:0]             z;
    logic [2:0][COORD_WIDTH-1:0]    vec;
    logic [2:0]                     neg;
    logic [2:0][MAG_W-1:0]          sm;
  } que_t;

  function automatic logic [31:0] atan_at(input int i);
    logic [31:0] r;
    case (i)
      0:  r = 32'h20000000;
      1:  r = 32'h12E4051E;
      2:  r = 32'h09FB385B;
      3:  r = 32'h051111D4;
      4:  r = 32'h028B0D43;
      5:  r = 32'h0145D7E1;
      6:  r = 32'h00A2F61E;
      7:  r = 32'h00517C55;
      8:  r = 32'h0028BE53;
      9:  r = 32'h00145F2F;
      10: r = 32'h000A2F98;
      11: r = 32'h000517CC;
      12: r = 32'h00028BE6;
      13: r = 32'h000145F3;
      14: r = 32'h0000A2FA;
      15: r = 32'h0000517D;
      16: r = 32'h000028BE;
      17: r = 32'h0000145F;
      18: r = 32'h00000A30;
      19: r = 32'h00000518;
      20: r = 32'h0000028C;
      21: r = 32'h00000146;
      22: r = 32'h000000A3;
      23: r = 32'h00000051;
      24: r = 32'h00000029;
      25: r = 32'h00000014;
      26: r = 32'h0000000A;
      27: r = 32'h00000005;
      28: r = 32'h00000003;
      29: r = 32'h00000001;
      default: r = 32'h00000000;
    endcase
    return r;
  endfunction

  // Signed Q2.30 product, rounded half up.
  function automatic logic [QW-1:0] mul_q30(input logic [QW-1:0] a, input logic [QW-1:0] b);
    logic signed [63:0] p;
    p = $signed(a) * $signed(b);
    p = p + 64'sd536870912;
    return p[61:30];
  endfunction

  function automatic logic [QW-1:0] clamp_q30(input logic signed [34:0] v);
    logic [QW-1:0] r;
    if (v > 35'sd1073741824) begin
      r = 32'h40000000;
    end else if (v < -35'sd1073741824) begin
      r = 32'hC0000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

FILE: design/aavr_front.sv
module aavr_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  aavr_pkg::in_t     in_data,
  output logic              q_valid,
  input  logic              q_ready,
  output aavr_pkg::que_t    q_data
);

  localparam int CW = aavr_pkg::COORD_WIDTH;
  localparam int MW = aavr_pkg::MAG_W;
  localparam int PW = aavr_pkg::PHASE_W;

  logic          fv_r;
  aavr_pkg::in_t fd_r;

  assign in_ready = !fv_r || q_ready;
  assign q_valid  = fv_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fv_r <= 1'b0;
    end else if (in_valid && in_ready) begin
      fv_r <= 1'b1;
    end else if (q_ready) begin
      fv_r <= 1'b0;
    end
    if (in_valid && in_ready) begin
      fd_r <= in_data;
    end
  end

  // Classify: null axis, axis signs and magnitudes, the half-angle phase, and a
  // common left shift that puts the largest magnitude's top bit at 2^30.
  always_comb begin
    logic [2:0][CW-1:0] ax;
    logic [2:0][CW-1:0] am;
    logic [CW-1:0]      orv;
    logic [MW-1:0]      x;
    logic [2:0][MW-1:0] s;
    logic [PW-1:0]      p;
    ax[0] = fd_r.axis_x;
    ax[1] = fd_r.axis_y;
    ax[2] = fd_r.axis_z;
    for (int i = 0; i < 3; i++) begin
      am[i] = ax[i][CW-1] ? (~ax[i] + CW'(1)) : ax[i];
      s[i]  = MW'(am[i]);
    end
    orv = am[0] | am[1] | am[2];
    x   = MW'(orv);
    if (x[MW-1 -: 16] == '0) begin
      x = x << 16;
      for (int i = 0; i < 3; i++) s[i] = s[i] << 16;
    end
    if (x[MW-1 -: 8] == '0) begin
      x = x << 8;
      for (int i = 0; i < 3; i++) s[i] = s[i] << 8;
    end
    if (x[MW-1 -: 4] == '0) begin
      x = x << 4;
      for (int i = 0; i < 3; i++) s[i] = s[i] << 4;
    end
    if (x[MW-1 -: 2] == '0) begin
      x = x << 2;
      for (int i = 0; i < 3; i++) s[i] = s[i] << 2;
    end
    if (x[MW-1] == 1'b0) begin
      for (int i = 0; i < 3; i++) s[i] = s[i] << 1;
    end
    p = PW'(fd_r.turn_angle) << (PW - aavr_pkg::ANGLE_BITS);

    q_data.nul    = (orv == '0);
    q_data.swap   = p[PW-1];
    q_data.z      = p[PW-2:0];
    q_data.vec[0] = fd_r.vec_x;
    q_data.vec[1] = fd_r.vec_y;
    q_data.vec[2] = fd_r.vec_z;
    for (int i = 0; i < 3; i++) begin
      q_data.neg[i] = ax[i][CW-1];
      q_data.sm[i]  = s[i];
    end
  end

endmodule

FILE: design/aavr_queue.sv
module aavr_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push_valid,
  output logic            push_ready,
  input  aavr_pkg::que_t  push_data,
  output logic            pop_valid,
  input  logic            pop_ready,
  output aavr_pkg::que_t  pop_data
);

  aavr_pkg::que_t mem_r [2];
  logic           wp_r;
  logic           rp_r;
  logic [1:0]     cnt_r;
  logic           push;
  logic           pop;

  assign push_ready = (cnt_r != 2'd2);
  assign pop_valid  = (cnt_r != 2'd0);
  assign pop_data   = mem_r[rp_r];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= !wp_r;
      if (pop)  rp_r <= !rp_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
    if (push) begin
      mem_r[wp_r] <= push_data;
    end
  end

endmodule

FILE: design/aavr_back.sv
module aavr_back (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            q_valid,
  output logic            q_pop,
  input  aavr_pkg::que_t  q_data,
  output logic            out_valid,
  input  logic            out_ready,
  output aavr_pkg::out_t  out_data
);

  localparam int CW  = aavr_pkg::COORD_WIDTH;
  localparam int MW  = aavr_pkg::MAG_W;
  localparam int QW  = aavr_pkg::QW;
  localparam int NST = 71;
  localparam int AW  = CW + QW + 2;

  typedef struct packed {
    logic                     valid;
    logic                     nul;
    logic                     swap;
    logic [2:0][CW-1:0]       vec;
    logic [2:0]               neg;
    logic [2:0][MW-1:0]       sm;
    logic [2:0][2*MW-1:0]     sq;
    logic [63:0]              n;
    logic [63:0]              res;
    logic [31:0]              len;
    logic [2:0][61:0]         num;
    logic [2:0][31:0]         rem;
    logic [2:0][30:0]         quo;
    logic signed [32:0]       cx;
    logic signed [32:0]       cy;
    logic signed [31:0]       cz;
    logic [2:0][QW-1:0]       u;
    logic [QW-1:0]            sn;
    logic [QW-1:0]            cs;
    logic [2:0][QW-1:0]       qv;
    logic [QW-1:0]            qw;
    logic [8:0][QW-1:0]       pp;
    logic [8:0][QW-1:0]       mm;
    logic [8:0][CW+QW-1:0]    vp;
  } st_t;

  st_t            st_r   [NST];
  st_t            st_nxt [NST];
  st_t            src    [NST];
  st_t            init;
  logic           ov_r;
  aavr_pkg::out_t od_r;
  aavr_pkg::out_t od_nxt;
  logic           en;

  assign en        = !ov_r || out_ready;
  assign q_pop     = en && q_valid;
  assign out_valid = ov_r;
  assign out_data  = od_r;

  always_comb begin
    init       = '0;
    init.valid = q_valid;
    init.nul   = q_data.nul;
    init.swap  = q_data.swap;
    init.vec   = q_data.vec;
    init.neg   = q_data.neg;
    init.sm    = q_data.sm;
    init.cx    = aavr_pkg::CORDIC_GAIN;
    init.cy    = '0;
    init.cz    = $signed({2'b00, q_data.z});
  end

  for (genvar k = 0; k < NST; k++) begin : g_st
    localparam int CI = (k >= 1 && k <= 30) ? k - 1 : 0;
    localparam int SJ = (k >= 2 && k <= 33) ? 62 - 2 * (k - 2) : 0;
    localparam int DB = (k >= 35 && k <= 65) ? 30 - (k - 35) : 0;

    if (k == 0) begin : g_in
      assign src[k] = init;
    end else begin : g_pr
      assign src[k] = st_r[k-1];
    end

    always_comb begin
      st_t                   nx;
      logic signed [32:0]    dx;
      logic signed [32:0]    dy;
      logic [63:0]           bitv;
      logic [63:0]           cand;
      logic [32:0]           dc;
      logic [30:0]           qc;
      logic [QW-1:0]         c0;
      logic [QW-1:0]         s0;
      logic signed [34:0]    e [9];
      logic signed [34:0]    one;
      logic signed [CW+QW-1:0] pr;
      nx  = src[k];
      one = 35'sd1073741824;
      dx  = '0;
      dy  = '0;
      bitv = '0;
      cand = '0;
      dc  = '0;
      qc  = '0;
      c0  = '0;
      s0  = '0;
      pr  = '0;
      for (int i = 0; i < 9; i++) e[i] = 35'($signed(nx.pp[i]));

      // Squares of the scaled axis magnitudes.
      if (k == 0) begin
        for (int i = 0; i < 3; i++) nx.sq[i] = (2*MW)'(nx.sm[i]) * (2*MW)'(nx.sm[i]);
      end
      // One CORDIC micro-rotation per stage for the half angle.
      if (k >= 1 && k <= 30) begin
        dx = nx.cy >>> CI;
        dy = nx.cx >>> CI;
        if (!nx.cz[31]) begin
          nx.cx = nx.cx - dx;
          nx.cy = nx.cy + dy;
          nx.cz = nx.cz - $signed(aavr_pkg::atan_at(CI));
        end else begin
          nx.cx = nx.cx + dx;
          nx.cy = nx.cy - dy;
          nx.cz = nx.cz + $signed(aavr_pkg::atan_at(CI));
        end
      end
      if (k == 1) begin
        nx.n   = 64'(nx.sq[0]) + 64'(nx.sq[1]) + 64'(nx.sq[2]);
        nx.res = '0;
      end
      // Square root, one result bit per stage.
      if (k >= 2 && k <= 33) begin
        bitv = 64'd1 << SJ;
        cand = nx.res + bitv;
        if (nx.n >= cand) begin
          nx.n   = nx.n - cand;
          nx.res = (nx.res >> 1) + bitv;
        end else begin
          nx.res = nx.res >> 1;
        end
      end
      if (k == 34) begin
        nx.len = nx.res[31:0];
        for (int i = 0; i < 3; i++) begin
          nx.num[i] = (62'(nx.sm[i]) << 30) + 62'(nx.len[31:1]);
          nx.rem[i] = 32'(nx.num[i][61:31]);
          nx.quo[i] = '0;
        end
      end
      // Rounded divide of each magnitude by the length, one quotient bit per stage.
      if (k >= 35 && k <= 65) begin
        for (int i = 0; i < 3; i++) begin
          dc = {nx.rem[i], nx.num[i][DB]};
          if (dc >= {1'b0, nx.len}) begin
            nx.rem[i]     = 32'(dc - {1'b0, nx.len});
            nx.quo[i][DB] = 1'b1;
          end else begin
            nx.rem[i] = dc[31:0];
          end
        end
      end
      if (k == 66) begin
        for (int i = 0; i < 3; i++) begin
          qc = (nx.quo[i] > 31'h40000000) ? 31'h40000000 : nx.quo[i];
          nx.u[i] = nx.neg[i] ? (~{1'b0, qc} + 32'd1) : {1'b0, qc};
        end
        c0 = aavr_pkg::clamp_q30(35'(nx.cx));
        s0 = aavr_pkg::clamp_q30(35'(nx.cy));
        // Past a quarter turn of half angle, start from the quarter point.
        nx.sn = nx.swap ? c0 : s0;
        nx.cs = nx.swap ? (~s0 + 32'd1) : c0;
      end
      if (k == 67) begin
        for (int i = 0; i < 3; i++) nx.qv[i] = aavr_pkg::mul_q30(nx.u[i], nx.sn);
        nx.qw = nx.cs;
      end
      if (k == 68) begin
        nx.pp[0] = aavr_pkg::mul_q30(nx.qv[0], nx.qv[0]);
        nx.pp[1] = aavr_pkg::mul_q30(nx.qv[0], nx.qv[1]);
        nx.pp[2] = aavr_pkg::mul_q30(nx.qv[0], nx.qv[2]);
        nx.pp[3] = aavr_pkg::mul_q30(nx.qv[1], nx.qv[1]);
        nx.pp[4] = aavr_pkg::mul_q30(nx.qv[1], nx.qv[2]);
        nx.pp[5] = aavr_pkg::mul_q30(nx.qv[2], nx.qv[2]);
        nx.pp[6] = aavr_pkg::mul_q30(nx.qw, nx.qv[0]);
        nx.pp[7] = aavr_pkg::mul_q30(nx.qw, nx.qv[1]);
        nx.pp[8] = aavr_pkg::mul_q30(nx.qw, nx.qv[2]);
      end
      // Rotation matrix; product order is xx xy xz yy yz zz wx wy wz.
      if (k == 69) begin
        nx.mm[0] = aavr_pkg::clamp_q30(one - ((e[3] + e[5]) <<< 1));
        nx.mm[1] = aavr_pkg::clamp_q30((e[1] - e[8]) <<< 1);
        nx.mm[2] = aavr_pkg::clamp_q30((e[2] + e[7]) <<< 1);
        nx.mm[3] = aavr_pkg::clamp_q30((e[1] + e[8]) <<< 1);
        nx.mm[4] = aavr_pkg::clamp_q30(one - ((e[0] + e[5]) <<< 1));
        nx.mm[5] = aavr_pkg::clamp_q30((e[4] - e[6]) <<< 1);
        nx.mm[6] = aavr_pkg::clamp_q30((e[2] - e[7]) <<< 1);
        nx.mm[7] = aavr_pkg::clamp_q30((e[4] + e[6]) <<< 1);
        nx.mm[8] = aavr_pkg::clamp_q30(one - ((e[0] + e[3]) <<< 1));
      end
      if (k == 70) begin
        for (int i = 0; i < 3; i++) begin
          for (int j = 0; j < 3; j++) begin
            pr = $signed(nx.vec[j]) * $signed(nx.mm[i*3+j]);
            nx.vp[i*3+j] = pr;
          end
        end
      end
      st_nxt[k] = nx;
    end
  end

  // Row sums, rounding and saturation into the output register; a null axis passes the vector through.
  always_comb begin
    logic signed [AW-1:0] acc;
    logic signed [AW-1:0] omax;
    logic signed [AW-1:0] omin;
    logic [2:0][CW-1:0]   r;
    omax = AW'((64'sd1 <<< (CW - 1)) - 64'sd1);
    omin = -omax - AW'(1);
    for (int i = 0; i < 3; i++) begin
      acc = AW'($signed(st_r[NST-1].vp[i*3])) + AW'($signed(st_r[NST-1].vp[i*3+1]))
          + AW'($signed(st_r[NST-1].vp[i*3+2])) + AW'(64'sd536870912);
      acc = acc >>> 30;
      if (acc > omax) begin
        r[i] = omax[CW-1:0];
      end else if (acc < omin) begin
        r[i] = omin[CW-1:0];
      end else begin
        r[i] = acc[CW-1:0];
      end
      if (st_r[NST-1].nul) r[i] = st_r[NST-1].vec[i];
    end
    od_nxt.out_x     = r[0];
    od_nxt.out_y     = r[1];
    od_nxt.out_z     = r[2];
    od_nxt.axis_null = st_r[NST-1].nul;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
      for (int k = 0; k < NST; k++) st_r[k].valid <= 1'b0;
    end else if (en) begin
      ov_r <= st_r[NST-1].valid;
      for (int k = 0; k < NST; k++) st_r[k] <= st_nxt[k];
    end
    if (en) begin
      od_r <= od_nxt;
    end
  end

endmodule

FILE: design/axis_angle_vector_rotate_top.sv
// Channel   Direction  Handshake            Word
// in_       input      in_valid/in_ready    aavr_pkg::in_t: vector, axis, turn angle
// out_      output     out_valid/out_ready  aavr_pkg::out_t: rotated vector, axis_null
//
// One word is accepted per cycle and one result leaves per cycle when the
// consumer keeps out_ready high. An accepted word passes in turn through the
// front-end register, the queue and 71 pipeline stages (32 square-root steps
// and 31 divide steps dominate), and then the output register, which raises
// out_valid. Reset is synchronous and clears all valid state. When out_ready
// is low with a result waiting, the pipeline freezes and the two-entry queue
// plus the front register absorb the next words before in_ready drops.
module axis_angle_vector_rotate_top (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  aavr_pkg::in_t  in_data,
  output logic           out_valid,
  input  logic           out_ready,
  output aavr_pkg::out_t out_data
);

  // Front end to queue.
  logic           fq_valid;
  logic           fq_ready;
  aavr_pkg::que_t fq_data;

  // Queue to rotation pipeline.
  logic           qb_valid;
  logic           qb_pop;
  aavr_pkg::que_t qb_data;

  // The front end registers the word and classifies it: null axis, signs,
  // the half-angle phase, and the axis magnitudes shifted so the largest sits at 2^30.
  aavr_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .q_valid  (fq_valid),
    .q_ready  (fq_ready),
    .q_data   (fq_data)
  );

  // A short queue decouples the front end from pipeline stalls.
  aavr_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (fq_valid),
    .push_ready (fq_ready),
    .push_data  (fq_data),
    .pop_valid  (qb_valid),
    .pop_ready  (qb_pop),
    .pop_data   (qb_data)
  );

  // The back end normalizes the axis, runs the half-angle CORDIC in parallel,
  // builds the quaternion and matrix, and applies it to the vector.
  aavr_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (qb_valid),
    .q_pop     (qb_pop),
    .q_data    (qb_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

FILE: design/aavr_checker.sv
module aavr_checker (
  input logic           clk,
  input logic           rst_n,
  input logic           in_ready,
  input logic           out_valid,
  input logic           out_ready,
  input aavr_pkg::out_t out_data
);

  // A result that is not taken stays on the port unchanged.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // Reset empties the output register.
  a_rst_out: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // Reset empties the front register, so the block can take a word at once.
  a_rst_in: assert property (@(posedge clk) !rst_n |=> in_ready)
    else $error("input not ready after reset");

endmodule

bind axis_angle_vector_rotate_top aavr_checker u_aavr_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
